// File: hw/rtl/crossfade_sample_router_unit_defines.svh
// Assertion macros for the crossfade sample router.
// Used by crossfade_sample_router_unit; the caller provides clk and rst_n.
`ifndef CROSSFADE_SAMPLE_ROUTER_UNIT_DEFINES_SVH
`define CROSSFADE_SAMPLE_ROUTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CFSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CFSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cfsr_pkg.sv
// Package for the crossfade sample router: widths, front state type,
// descriptor passed from front to back, and the outlet count clamp.
`timescale 1ns / 1ps
`default_nettype none
package cfsr_pkg;

  localparam int MAX_OUTLETS = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 8;
  localparam int POS_BITS    = 16;
  localparam int IPART_BITS  = POS_BITS - FRAC_BITS;
  localparam int CNT_W       = 5;
  localparam int IDX_W       = 4;
  localparam int DIV_CNT_W   = $clog2(IPART_BITS);
  localparam int PROD_W      = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CNT_W-1:0] PREV_RESET = '1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]              n;
    logic [IDX_W-1:0]              cur;
    logic [IDX_W-1:0]              nb;
    logic signed [SAMPLE_BITS-1:0] cur_val;
    logic signed [SAMPLE_BITS-1:0] nb_val;
    logic                          sync;
  } cfsr_desc_t;

  // Clamp the raw register to 1..MAX_OUTLETS.
  function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] n;
    n = raw;
    if (raw == '0) n = CNT_W'(1);
    else if (raw > CNT_W'(MAX_OUTLETS)) n = CNT_W'(MAX_OUTLETS);
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/crossfade_sample_router_unit.sv
// Crossfade sample router, top level: config register, front, queue, back.
// Depends on cfsr_pkg, cfsr_front, cfsr_fifo, cfsr_back and the defines header.
//
// Each input beat (a signed sample and a signed Q8.8 position) is spread
// over outlet_count outlets (1..16; 0 reads as 1, above 16 as 16). The
// integer part of the position, rounded toward zero, wraps around the ring
// to pick the current outlet; a nonzero fraction hands floor(sample*|frac|/256)
// to the next outlet (positive) or the previous one (negative) and the current
// outlet keeps the rest. One result beat per active outlet leaves in ascending
// order, last_outlet marking the final one and sync_flag set when the current
// outlet moved since the previous item. The front works through an item in
// steps: the accept, a one-bit-per-cycle remainder of the integer part
// against the outlet count, a multiply and the hand-off of the item to a
// two-entry queue, which waits while the queue is full; it takes no new beat
// until that hand-off. The back sends one result beat per cycle while the
// output register is empty or popped, one item's beats after another. Write cfg only while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "crossfade_sample_router_unit_defines.svh"
module crossfade_sample_router_unit import cfsr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic signed [POS_BITS-1:0]    in_position,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [IDX_W-1:0]              out_outlet_index,
  output logic signed [SAMPLE_BITS-1:0] out_outlet_value,
  output logic                          out_sync_flag,
  output logic                          out_last_outlet,
  input  logic                          cfg_wr_en,
  input  logic [CNT_W-1:0]              cfg_wr_data
);

  logic [CNT_W-1:0] outlet_count_r, outlet_count_nxt;
  logic [CNT_W-1:0] n_act;
  logic             fifo_push, fifo_full, fifo_pop, fifo_empty;
  cfsr_desc_t       fifo_wr, fifo_rd;
  logic             out_top_hit;

  // Hold the register unless written; clamp once for the whole block.
  assign outlet_count_nxt = cfg_wr_en ? cfg_wr_data : outlet_count_r;
  assign n_act            = active_count(outlet_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outlet_count_r <= CNT_W'(1);
    end else begin
      outlet_count_r <= outlet_count_nxt;
    end
  end

  // Front: accept, wrap and split into two shares.
  cfsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .sample_in (in_sample_in),
    .position  (in_position),
    .n_act     (n_act),
    .q_push    (fifo_push),
    .q_full    (fifo_full),
    .q_data    (fifo_wr)
  );

  // Queue: decouple the front from a stalled result side.
  cfsr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fifo_push),
    .wr_data (fifo_wr),
    .full    (fifo_full),
    .pop     (fifo_pop),
    .rd_data (fifo_rd),
    .empty   (fifo_empty)
  );

  // Back: advance through the outlets, one result beat per cycle while the output is not held.
  cfsr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (fifo_empty),
    .q_data           (fifo_rd),
    .q_pop            (fifo_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_outlet_index (out_outlet_index),
    .out_outlet_value (out_outlet_value),
    .out_sync_flag    (out_sync_flag),
    .out_last_outlet  (out_last_outlet)
  );

  // Result beat sits on the highest active outlet.
  assign out_top_hit = ({1'b0, out_outlet_index} == (n_act - 1'b1));

  // The front never drives a beat into a full queue.
  `CFSR_ASSERT_IMP(a_no_push_full, fifo_push, !fifo_full, "push into full queue")
  // An accepted beat keeps the front busy for the next cycle.
  `CFSR_ASSERT_NXT(a_busy_after_accept, in_push && !in_full, in_full, "front not busy")
  // The last result beat of an item is for the highest active outlet.
  `CFSR_ASSERT_IMP(a_last_index, !out_empty && out_last_outlet, out_top_hit, "last beat on wrong outlet")

endmodule
`default_nettype wire

// File: hw/rtl/cfsr_fifo.sv
// Two-entry descriptor queue between router front and back.
// Depends on cfsr_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`default_nettype none
module cfsr_fifo import cfsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cfsr_desc_t wr_data,
  output logic       full,
  input  logic       pop,
  output cfsr_desc_t rd_data,
  output logic       empty
);

  cfsr_desc_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule
`default_nettype wire

// File: hw/rtl/cfsr_front.sv
// Router front: accepts a beat, wraps the integer part by the outlet count
// with a bit-serial remainder, forms both shares. Depends on cfsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfsr_front import cfsr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [POS_BITS-1:0]    position,
  input  logic [CNT_W-1:0]              n_act,
  output logic                          q_push,
  input  logic                          q_full,
  output cfsr_desc_t                    q_data
);

  front_state_t                  state_r, state_nxt;
  logic [DIV_CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                          neg_r, neg_nxt;
  logic [FRAC_BITS-1:0]          fmag_r, fmag_nxt;
  logic [IPART_BITS-1:0]         div_r, div_nxt;
  logic [CNT_W-1:0]              rem_r, rem_nxt;
  logic [CNT_W-1:0]              n_r, n_nxt;
  logic [IDX_W-1:0]              cur_r, cur_nxt;
  logic [IDX_W-1:0]              nb_r, nb_nxt;
  logic                          whole_r, whole_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic [CNT_W-1:0]              prev_r, prev_nxt;

  logic                          accept;
  logic [POS_BITS-1:0]           mag;
  logic [CNT_W-1:0]              trial;
  logic [CNT_W-1:0]              cur_w;
  logic [CNT_W-1:0]              cur_inc;
  logic signed [PROD_W-1:0]      shifted;
  logic signed [SAMPLE_BITS-1:0] share;

  assign accept = push && !full;
  assign mag    = position[POS_BITS-1] ? (~$unsigned(position) + 1'b1) : $unsigned(position);
  assign trial  = {rem_r[CNT_W-2:0], div_r[IPART_BITS-1]};

  // Wrap: a negative remainder folds back from the top of the ring.
  assign cur_w   = (neg_r && rem_r != '0) ? (n_r - rem_r) : rem_r;
  assign cur_inc = cur_w + 1'b1;

  assign shifted = prod_r >>> FRAC_BITS;
  assign share   = whole_r ? '0 : shifted[SAMPLE_BITS-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (push) state_nxt = F_DIV;
      F_DIV:   if (cnt_r == DIV_CNT_W'(IPART_BITS - 1)) state_nxt = F_MUL;
      F_MUL:   state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    case (state_r)
      F_IDLE:  full = 1'b0;
      F_PUSH:  q_push = !q_full;
      default: begin
        full   = 1'b1;
        q_push = 1'b0;
      end
    endcase
  end

  // Datapath.
  always_comb begin
    cnt_nxt    = cnt_r;
    sample_nxt = sample_r;
    neg_nxt    = neg_r;
    fmag_nxt   = fmag_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    n_nxt      = n_r;
    cur_nxt    = cur_r;
    nb_nxt     = nb_r;
    whole_nxt  = whole_r;
    prod_nxt   = prod_r;
    prev_nxt   = prev_r;
    if (accept) begin
      cnt_nxt    = '0;
      sample_nxt = sample_in;
      neg_nxt    = position[POS_BITS-1];
      fmag_nxt   = mag[FRAC_BITS-1:0];
      div_nxt    = mag[POS_BITS-1:FRAC_BITS];
      rem_nxt    = '0;
      n_nxt      = n_act;
    end
    if (state_r == F_DIV) begin
      cnt_nxt = cnt_r + 1'b1;
      div_nxt = div_r << 1;
      rem_nxt = (trial >= n_r) ? (trial - n_r) : trial;
    end
    if (state_r == F_MUL) begin
      cur_nxt   = cur_w[IDX_W-1:0];
      whole_nxt = (fmag_r == '0) || (n_r == CNT_W'(1));
      prod_nxt  = PROD_W'(sample_r) * PROD_W'($signed({1'b0, fmag_r}));
      if (!neg_r) begin
        nb_nxt = (cur_inc == n_r) ? '0 : cur_inc[IDX_W-1:0];
      end else begin
        nb_nxt = (cur_w == '0) ? IDX_W'(n_r - 1'b1) : IDX_W'(cur_w - 1'b1);
      end
    end
    if (q_push) prev_nxt = {1'b0, cur_r};
  end

  always_comb begin
    q_data.n       = n_r;
    q_data.cur     = cur_r;
    q_data.nb      = nb_r;
    q_data.cur_val = sample_r - share;
    q_data.nb_val  = share;
    q_data.sync    = ({1'b0, cur_r} != prev_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      prev_r  <= PREV_RESET;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    sample_r <= sample_nxt;
    neg_r    <= neg_nxt;
    fmag_r   <= fmag_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    n_r      <= n_nxt;
    cur_r    <= cur_nxt;
    nb_r     <= nb_nxt;
    whole_r  <= whole_nxt;
    prod_r   <= prod_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/cfsr_back.sv
// Router back: walks the outlets of the head descriptor, one result beat per
// cycle into an output register while it is empty or popped. Depends on cfsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfsr_back import cfsr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  cfsr_desc_t                    q_data,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [IDX_W-1:0]              out_outlet_index,
  output logic signed [SAMPLE_BITS-1:0] out_outlet_value,
  output logic                          out_sync_flag,
  output logic                          out_last_outlet
);

  logic                          ov_r, ov_nxt;
  logic [IDX_W-1:0]              k_r, k_nxt;
  logic [IDX_W-1:0]              idx_r;
  logic signed [SAMPLE_BITS-1:0] val_r;
  logic                          sync_r, last_r;
  logic                          step, emit, last_k;
  logic signed [SAMPLE_BITS-1:0] val_w;

  assign step   = !ov_r || out_pop;
  assign emit   = step && !q_empty;
  assign last_k = ({1'b0, k_r} == (q_data.n - 1'b1));
  assign q_pop  = emit && last_k;

  always_comb begin
    if (k_r == q_data.cur)     val_w = q_data.cur_val;
    else if (k_r == q_data.nb) val_w = q_data.nb_val;
    else                       val_w = '0;
  end

  always_comb begin
    ov_nxt = ov_r;
    k_nxt  = k_r;
    if (emit) begin
      ov_nxt = 1'b1;
      k_nxt  = last_k ? '0 : k_r + 1'b1;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      k_r  <= '0;
    end else begin
      ov_r <= ov_nxt;
      k_r  <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      idx_r  <= k_r;
      val_r  <= val_w;
      sync_r <= q_data.sync;
      last_r <= last_k;
    end
  end

  assign out_empty        = !ov_r;
  assign out_outlet_index = idx_r;
  assign out_outlet_value = val_r;
  assign out_sync_flag    = sync_r;
  assign out_last_outlet  = last_r;

endmodule
`default_nettype wire

// File: tb/crossfade_sample_router_unit_tb.sv
// Self-checking testbench for crossfade_sample_router_unit: queue-style beats in and out,
// one outlet_count register, expected outlet shares computed alongside the stimulus.
// Depends on cfsr_pkg and the RTL of crossfade_sample_router_unit only.
`timescale 1ns / 1ps
module crossfade_sample_router_unit_tb;
  import cfsr_pkg::*;

  // Generous ceiling: roughly 400 items, some in a heavily idling phase, plus
  // drains and the long receiver hold, taken several times over.
  localparam int CYCLE_LIMIT   = 500000;
  // Time for the front and back to go idle once the last expected beat is out.
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int CHUNK_ITEMS   = 30;
  localparam int PRINT_CAP     = 200;

  typedef struct {
    logic [IDX_W-1:0]              index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          sync;
    logic                          last;
  } outlet_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic signed [POS_BITS-1:0]    in_position = '0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic [IDX_W-1:0]              out_outlet_index;
  logic signed [SAMPLE_BITS-1:0] out_outlet_value;
  logic                          out_sync_flag;
  logic                          out_last_outlet;
  logic                          cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]              cfg_wr_data = '0;

  // Shadow of the block: raw register value and the outlet picked by the last item.
  logic [CNT_W-1:0] ring_raw = CNT_W'(1);
  logic [CNT_W-1:0] prev_outlet = '1;

  outlet_beat_t pending_shares[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           idle_pct = 0;    // chance in 100 that the sender skips a cycle
  int           stall_pct = 0;   // chance in 100 that the receiver holds pop low
  logic         stall_hold = 1'b0;
  int           hold_cnt = 0;

  always #5 clk = ~clk;

  crossfade_sample_router_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample_in     (in_sample_in),
    .in_position      (in_position),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_outlet_index (out_outlet_index),
    .out_outlet_value (out_outlet_value),
    .out_sync_flag    (out_sync_flag),
    .out_last_outlet  (out_last_outlet),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // Hard stop if the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    // Print only up to the cap so a badly broken block cannot flood the log, but keep counting past it.
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Compute the outlet shares one item produces and queue them in outlet order.
  function automatic void predict_outlet_shares(input logic signed [SAMPLE_BITS-1:0] sample,
                                                input logic signed [POS_BITS-1:0] pos);
    int unsigned  n;
    int unsigned  mag;
    int unsigned  ipart;
    int unsigned  fmag;
    int unsigned  r;
    int unsigned  cur;
    int unsigned  nb;
    longint       shares[MAX_OUTLETS];
    longint       part;
    bit           neg;
    bit           moved;
    outlet_beat_t b;
    // Clamp the register: zero reads as one outlet, anything past the ring as the full ring.
    if (ring_raw == '0) n = 1;
    else if (ring_raw > CNT_W'(MAX_OUTLETS)) n = MAX_OUTLETS;
    else n = ring_raw;
    // Split the position toward zero: magnitude gives integer part and fraction.
    neg   = (pos < 0);
    mag   = neg ? -int'(pos) : int'(pos);
    ipart = mag >> FRAC_BITS;
    fmag  = mag & ((1 << FRAC_BITS) - 1);
    r     = ipart % n;
    cur   = (neg && r != 0) ? n - r : r;
    foreach (shares[k]) shares[k] = 0;
    if (fmag == 0 || n == 1) begin
      shares[cur] = sample;
    end else begin
      // Arithmetic shift of the exact product floors toward minus infinity.
      part = (longint'(sample) * longint'(fmag)) >>> FRAC_BITS;
      if (!neg) nb = (cur + 1 == n) ? 0 : cur + 1;
      else nb = (cur == 0) ? n - 1 : cur - 1;
      shares[cur] = longint'(sample) - part;
      shares[nb]  = part;
    end
    moved       = (cur != prev_outlet);
    prev_outlet = CNT_W'(cur);
    for (int k = 0; k < n; k++) begin
      b.index = IDX_W'(k);
      b.value = shares[k][SAMPLE_BITS-1:0];
      b.sync  = moved;
      b.last  = (k + 1 == n);
      pending_shares.push_back(b);
    end
  endfunction

  // Offer one beat, idling first at random, and hold it until the block takes it.
  // Push is left high on return so back-to-back beats never toggle it within a step.
  task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] sample,
                           input logic signed [POS_BITS-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_sample_in <= sample;
    in_position  <= pos;
    do @(posedge clk); while (in_full);
    predict_outlet_shares(sample, pos);
  endtask

  // Stop offering, wait for every pending beat, then let the pipeline settle.
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_shares.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_outlet_count(input logic [CNT_W-1:0] count);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    ring_raw = count;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(7))
      0: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2: s = $urandom_range(1) ? '0 : '1;
      default: s = SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  // Mix of full-range positions, whole positions, positions near the ring and
  // positions that keep the prior integer part (so the outlet often stays put).
  function automatic logic signed [POS_BITS-1:0] pick_position(
      input logic signed [POS_BITS-1:0] prior);
    logic signed [POS_BITS-1:0] p;
    case ($urandom_range(3))
      0: p = POS_BITS'($urandom);
      1: begin
        p = POS_BITS'($urandom);
        p[FRAC_BITS-1:0] = '0;
      end
      2: begin
        p = POS_BITS'($urandom_range(0, 20 << FRAC_BITS));
        if ($urandom_range(1)) p = -p;
      end
      default: begin
        p = prior;
        p[FRAC_BITS-1:0] = FRAC_BITS'($urandom);
      end
    endcase
    return p;
  endfunction

  // Receiver: random pops, or a long counted hold-off while stall_hold is raised.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      hold_cnt <= 0;
    end else if (stall_hold && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_pop  <= 1'b0;
    end else begin
      if (!stall_hold) hold_cnt <= 0;
      out_pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each accepted result beat against the oldest expected one.
  always @(posedge clk) begin : check_beats
    outlet_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_shares.size() == 0) begin
        report_mismatch($sformatf("unexpected beat outlet %0d value %0d",
                                  out_outlet_index, out_outlet_value));
      end else begin
        want = pending_shares.pop_front();
        if (out_outlet_index !== want.index)
          report_mismatch($sformatf("outlet_index %0d, want %0d",
                                    out_outlet_index, want.index));
        if (out_outlet_value !== want.value)
          report_mismatch($sformatf("outlet %0d value %0d, want %0d",
                                    want.index, out_outlet_value, want.value));
        if (out_sync_flag !== want.sync)
          report_mismatch($sformatf("outlet %0d sync_flag %b, want %b",
                                    want.index, out_sync_flag, want.sync));
        if (out_last_outlet !== want.last)
          report_mismatch($sformatf("outlet %0d last_outlet %b, want %b",
                                    want.index, out_last_outlet, want.last));
      end
    end
  end

  // Reset count is one outlet: fraction must be ignored, whole sample goes out.
  task automatic test_single_outlet_default();
    send_beat(24'sh7FFFFF, 16'sh0080);
    send_beat(24'sh800000, 16'sh8000);
    send_beat(24'sh000000, 16'sh7FFF);
  endtask

  // Zero reads as one outlet; values above the ring clamp to sixteen.
  task automatic test_outlet_count_limits();
    set_outlet_count(CNT_W'(0));
    send_beat(24'sh123456, 16'sh0340);
    set_outlet_count('1);
    send_beat(24'sh7FFFFF, 16'sh0F80);   // outlet 15, crossfade wraps to 0
    send_beat(24'sh800000, 16'shFF01);   // outlet 0, crossfade wraps back to 15
    set_outlet_count(CNT_W'(17));
    send_beat(24'shFFFFFF, 16'sh1140);
  endtask

  // Four outlets: zero fraction, tiny and full fractions, negative wrap-around,
  // integer parts past the ring and the position extremes.
  task automatic test_crossfade_directed();
    set_outlet_count(CNT_W'(4));
    send_beat(24'sh7FFFFF, 16'sh0000);
    send_beat(24'sh800000, 16'sh0001);
    send_beat(24'sh7FFFFF, 16'sh00FF);
    send_beat(24'sh800000, 16'sh00FF);
    send_beat(24'shFFFFFF, 16'sh0380);
    send_beat(24'sh123456, 16'shFF80);   // -0.5: outlet 0, share to outlet 3
    send_beat(24'sh800000, 16'shFE40);   // -1.75: outlet 3, share to outlet 2
    send_beat(24'sh7FFFFF, 16'shFC00);   // -4.0: wraps to outlet 0, no share
    send_beat(24'sh000001, 16'sh8000);
    send_beat(24'shFFFFFF, 16'sh7FFF);
    send_beat(24'sh400000, 16'sh0580);
    send_beat(24'sh000000, 16'sh0280);
    send_beat(24'shABCDEF, 16'sh0240);   // same outlet as before: sync low
  endtask

  // Random items in chunks, each chunk under a fresh random outlet count.
  task automatic test_random_phase(input int send_idle, input int recv_stall, input int items);
    logic signed [POS_BITS-1:0] pos;
    pos        = '0;
    idle_pct   = send_idle;
    stall_pct  = recv_stall;
    for (int sent = 0; sent < items; sent += CHUNK_ITEMS) begin
      set_outlet_count(CNT_W'($urandom_range(0, 31)));
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        pos = pick_position(pos);
        send_beat(pick_sample(), pos);
      end
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps pushing,
  // so the queue fills and in_full stalls the input side.
  task automatic test_queue_backpressure();
    logic signed [POS_BITS-1:0] pos;
    pos = '0;
    set_outlet_count(CNT_W'(16));
    idle_pct   = 0;
    stall_pct  = 0;
    stall_hold <= 1'b1;
    for (int k = 0; k < 12; k++) begin
      pos = pick_position(pos);
      send_beat(pick_sample(), pos);
    end
    stall_hold <= 1'b0;
    drain_results();
  endtask

  initial begin
    // Hold reset from the start, release it once, and never assert it again.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_outlet_default();
    test_outlet_count_limits();
    test_crossfade_directed();
    test_random_phase(0, 0, 90);
    test_random_phase(67, 0, 90);
    test_random_phase(0, 67, 90);
    test_random_phase(21, 21, 90);
    test_queue_backpressure();
    drain_results();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
